@@ rtl/core/nfrc_pkg.sv @@
// Package for the nearest-frame resampler and format converter.
// Item structs, register indexes, format codes and sample conversion.
// Used by rtl/core/nearest_frame_resample_format_convert_unit.sv; no dependencies.
package nfrc_pkg;

	localparam int unsigned MAX_SRC_FRAMES_DEF = 16384;

	localparam logic REG_DST_FORMAT    = 1'b0;
	localparam logic REG_SRC_IS_STEREO = 1'b1;

	localparam logic [2:0] FMT_I16   = 3'd0;
	localparam logic [2:0] FMT_FLOAT = 3'd1;
	localparam logic [2:0] FMT_I32   = 3'd2;
	localparam logic [2:0] FMT_I24   = 3'd3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EMIT = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic               first_of_block;
		logic signed [15:0] src_left;
		logic signed [15:0] src_right;
		logic        [15:0] dst_frame_total;
	} req_t;

	typedef struct packed {
		logic [31:0] out_ch0;
		logic [31:0] out_ch1;
		logic        last_frame;
		logic        empty_source;
	} rsp_t;

	// exact single-precision bits of s / 32768
	function automatic logic [31:0] to_float_bits(input logic [15:0] s);
		logic [15:0] mag;
		logic [3:0]  p;
		logic [38:0] sh;
		logic [7:0]  expo;
		mag = s[15] ? 16'(-s) : s;
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) begin
				p = 4'(i);
			end
		end
		sh = 39'(mag) << (5'd23 - {1'b0, p});
		expo = 8'({4'd0, p} + 8'd112);
		if (s == 16'd0) begin
			return 32'd0;
		end
		return {s[15], expo, sh[22:0]};
	endfunction

	function automatic logic [31:0] convert(input logic [2:0] fmt, input logic [15:0] s);
		logic [31:0] r;
		unique case (fmt)
			FMT_I16:   r = {{16{s[15]}}, s};
			FMT_FLOAT: r = to_float_bits(s);
			FMT_I32:   r = {s, 16'd0};
			FMT_I24:   r = {{8{s[15]}}, s, 8'd0};
			default:   r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/nearest_frame_resample_format_convert_unit.sv @@
// Nearest-frame resampler and PCM format converter, top level.
// Frame store, restoring divider for source frame selection, output register.
// Depends on rtl/core/nfrc_pkg.sv.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------
//  req     | in        | req_valid/stall   | nfrc_pkg::req_t
//  rsp     | out       | rsp_valid/stall   | nfrc_pkg::rsp_t
//  cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// An emit steps through DIV, CLAMP, RD and OUT, with the one-bit-per-cycle divider in DIV;
// PW = 16 + clog2(MAX_SRC_FRAMES+1) (31 at default) is its dividend width. With at most one
// frame loaded or total at most one it skips DIV and CLAMP, with an empty store RD as well.
// req_stall is high while an emit is in progress or its result waits on the output register.
// Reset clears counters, configuration and control; the store holds no reset value.
module nearest_frame_resample_format_convert_unit #(
	parameter int unsigned MAX_SRC_FRAMES = nfrc_pkg::MAX_SRC_FRAMES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  nfrc_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output nfrc_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [2:0]      cfg_data
);

	localparam int unsigned LW = $clog2(MAX_SRC_FRAMES + 1);
	localparam int unsigned AW = $clog2(MAX_SRC_FRAMES);
	localparam int unsigned PW = 16 + LW;
	localparam int unsigned CW = $clog2(PW + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_CLAMP = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    dst_format_q;
	logic          src_is_stereo_q;
	logic [LW-1:0] loaded_q;
	logic [15:0]   idx_q;
	logic [15:0]   tot_q;
	logic [PW-1:0] dq_q;
	logic [15:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] sidx_q;
	logic          last_q;
	logic          empty_q;
	logic [31:0]   rd_data_q;
	logic [31:0]   mem [MAX_SRC_FRAMES];
	logic          rsp_valid_q;
	nfrc_pkg::rsp_t rsp_q;

	logic          accept;
	logic          do_load;
	logic [LW-1:0] load_base;
	logic          wr_en;
	logic [16:0]   r2;
	logic          qbit;
	logic          last_c;
	logic          out_free;
	logic [15:0]   smp_l;
	logic [15:0]   smp_r;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign do_load   = accept && (req.req_type == nfrc_pkg::REQ_LOAD);
	assign load_base = req.first_of_block ? '0 : loaded_q;
	assign wr_en     = do_load && (load_base < LW'(MAX_SRC_FRAMES));
	assign r2        = {rem_q, dq_q[PW-1]};
	assign qbit      = (r2 >= {1'b0, tot_q});
	assign last_c    = ((17'(idx_q) + 17'd1) == 17'(req.dst_frame_total));
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign smp_l     = rd_data_q[15:0];
	assign smp_r     = src_is_stereo_q ? rd_data_q[31:16] : rd_data_q[15:0];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_format_q    <= nfrc_pkg::FMT_I16;
			src_is_stereo_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nfrc_pkg::REG_DST_FORMAT:    dst_format_q    <= cfg_data;
				nfrc_pkg::REG_SRC_IS_STEREO: src_is_stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[load_base[AW-1:0]] <= {req.src_right, req.src_left};
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem[sidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						if (req.first_of_block) begin
							idx_q <= '0;
						end
						if (wr_en) begin
							loaded_q <= LW'(load_base + LW'(1));
						end else begin
							loaded_q <= load_base;
						end
					end else if (accept) begin
						idx_q <= last_c ? 16'd0 : 16'(idx_q + 16'd1);
						cnt_q <= '0;
						if (loaded_q == '0) begin
							state_q <= ST_OUT;
						end else if (loaded_q <= LW'(1) || req.dst_frame_total <= 16'd1) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= CW'(cnt_q + CW'(1));
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_RD;
				ST_RD:    state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == nfrc_pkg::REQ_EMIT) begin
			dq_q    <= PW'(idx_q * loaded_q);
			rem_q   <= '0;
			tot_q   <= req.dst_frame_total;
			sidx_q  <= '0;
			last_q  <= last_c;
			empty_q <= (loaded_q == '0);
		end else if (state_q == ST_DIV) begin
			rem_q <= qbit ? 16'(r2 - {1'b0, tot_q}) : r2[15:0];
			dq_q  <= {dq_q[PW-2:0], qbit};
		end else if (state_q == ST_CLAMP) begin
			if (dq_q >= PW'(loaded_q)) begin
				sidx_q <= AW'(LW'(loaded_q - LW'(1)));
			end else begin
				sidx_q <= dq_q[AW-1:0];
			end
		end
		if (state_q == ST_OUT && out_free) begin
			rsp_q.out_ch0      <= empty_q ? 32'd0 : nfrc_pkg::convert(dst_format_q, smp_l);
			rsp_q.out_ch1      <= empty_q ? 32'd0 : nfrc_pkg::convert(dst_format_q, smp_r);
			rsp_q.last_frame   <= last_q;
			rsp_q.empty_source <= empty_q;
		end
	end

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LW'(MAX_SRC_FRAMES))
		else $error("frame count above store depth");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CW'(PW))
		else $error("divider ran past dividend width");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> (LW'(sidx_q) < loaded_q))
		else $error("store read beyond loaded frames");

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_OUT))
		else $error("result shown outside output step");

endmodule

@@ test/nfrc_checker.sv @@
// Scoreboard for the nearest-frame resampler and format converter.
// Watches the req, rsp and cfg channels, keeps its own frame store and predicts each frame.
// Depends on rtl/core/nfrc_pkg.sv.
module nfrc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  nfrc_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  nfrc_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [2:0]     cfg_data,
	output int             errors,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = nfrc_pkg::MAX_SRC_FRAMES_DEF;

	logic [31:0]    frame_mem [STORE_DEPTH];
	int             held_frames;
	logic [15:0]    out_pos;
	logic [2:0]     fmt_sel;
	logic           stereo_sel;
	nfrc_pkg::rsp_t frames_due [$];

	function automatic logic [31:0] float_word(input int v);
		longint mag;
		int     e;
		if (v == 0) begin
			return '0;
		end
		mag = (v < 0) ? -v : v;
		e = 15;
		while ((mag >> e) == 0) begin
			e--;
		end
		return {(v < 0), 8'(e + 112), 23'(mag << (23 - e))};
	endfunction

	function automatic logic [31:0] pcm_word(input logic [15:0] s);
		int v;
		v = $signed(s);
		case (fmt_sel)
			nfrc_pkg::FMT_I16:   return 32'(v);
			nfrc_pkg::FMT_FLOAT: return float_word(v);
			nfrc_pkg::FMT_I32:   return 32'(v) << 16;
			nfrc_pkg::FMT_I24:   return 32'(v) << 8;
			default:             return '0;
		endcase
	endfunction

	function automatic int source_slot(input logic [15:0] pos, input logic [15:0] total);
		longint m;
		if (held_frames <= 1 || total <= 1) begin
			return 0;
		end
		m = longint'(pos) * held_frames / total;
		return (m >= held_frames) ? held_frames - 1 : int'(m);
	endfunction

	function automatic nfrc_pkg::rsp_t emit_frame(input logic [15:0] total);
		nfrc_pkg::rsp_t o;
		logic [31:0]    w;
		logic [15:0]    lft;
		logic [15:0]    rgt;
		o = '0;
		o.empty_source = (held_frames == 0);
		if (!o.empty_source) begin
			w = frame_mem[source_slot(out_pos, total)];
			lft = w[15:0];
			rgt = stereo_sel ? w[31:16] : lft;
			o.out_ch0 = pcm_word(lft);
			o.out_ch1 = pcm_word(rgt);
		end
		o.last_frame = (17'(out_pos) + 17'd1) == 17'(total);
		out_pos = o.last_frame ? '0 : out_pos + 16'd1;
		return o;
	endfunction

	always @(posedge clk) begin
		nfrc_pkg::rsp_t want;
		if (!arst_n) begin
			held_frames = 0;
			out_pos = '0;
			fmt_sel = nfrc_pkg::FMT_I16;
			stereo_sel = 1'b0;
			frames_due.delete();
			errors = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (frames_due.size() == 0) begin
					$error("unexpected frame: %h", rsp);
					errors++;
				end else begin
					want = frames_due.pop_front();
					if (want.out_ch0 !== rsp.out_ch0) begin
						$error("out_ch0: expected %h, got %h", want.out_ch0, rsp.out_ch0);
						errors++;
					end
					if (want.out_ch1 !== rsp.out_ch1) begin
						$error("out_ch1: expected %h, got %h", want.out_ch1, rsp.out_ch1);
						errors++;
					end
					if (want.last_frame !== rsp.last_frame) begin
						$error("last_frame: expected %b, got %b",
							want.last_frame, rsp.last_frame);
						errors++;
					end
					if (want.empty_source !== rsp.empty_source) begin
						$error("empty_source: expected %b, got %b",
							want.empty_source, rsp.empty_source);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == nfrc_pkg::REG_DST_FORMAT) begin
					fmt_sel = cfg_data;
				end else begin
					stereo_sel = cfg_data[0];
				end
			end
			if (req_valid && !req_stall) begin
				if (req.req_type == nfrc_pkg::REQ_LOAD) begin
					if (req.first_of_block) begin
						held_frames = 0;
						out_pos = '0;
					end
					if (held_frames < STORE_DEPTH) begin
						frame_mem[held_frames] = {req.src_right, req.src_left};
						held_frames++;
					end
				end else begin
					frames_due.push_back(emit_frame(req.dst_frame_total));
				end
			end
		end
		pending = frames_due.size();
	end

endmodule

@@ test/tb_nearest_frame_resample_format_convert_unit.sv @@
// Testbench top for nearest_frame_resample_format_convert_unit.
// Drives load/emit items and register writes with random idling; nfrc_checker scores the frames.
// Depends on rtl/core/nfrc_pkg.sv, the unit and test/nfrc_checker.sv.
module tb_nearest_frame_resample_format_convert_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT      = 1_500_000;
	localparam logic [2:0]  FMT_NONE   = 3'd4;
	localparam logic [2:0]  FMT_LAST   = 3'd7;
	localparam int          PHASES     = 10;
	localparam int          PHASE_LEN  = 125;
	localparam int          DRAIN_WAIT = 48;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	nfrc_pkg::req_t req_bus;
	logic           rsp_valid;
	logic           rsp_stall;
	nfrc_pkg::rsp_t rsp_bus;
	logic           cfg_valid;
	logic           cfg_ready;
	logic           cfg_index;
	logic [2:0]     cfg_data;
	int             errors;
	int             pending;
	bit             quiet;
	bit             hold_now;
	int unsigned    cycle_count = 0;

	logic [2:0] fmt_plan [PHASES] = '{nfrc_pkg::FMT_I16, nfrc_pkg::FMT_FLOAT,
		nfrc_pkg::FMT_I32, nfrc_pkg::FMT_I24, FMT_NONE, FMT_LAST, nfrc_pkg::FMT_I24,
		nfrc_pkg::FMT_FLOAT, nfrc_pkg::FMT_I16, nfrc_pkg::FMT_I32};

	always #2 clk = ~clk;

	nearest_frame_resample_format_convert_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_bus),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_bus),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nfrc_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_bus),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_bus),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int idle_cycles();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rnd_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rnd_total();
		case ($urandom_range(0, 11))
			0, 1: return 16'd0;
			2, 3: return 16'd1;
			4, 5: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		rsp_stall = 1'b0;
		forever begin
			n = idle_cycles();
			if (hold_now) begin
				n = 300;
				hold_now = 1'b0;
			end
			rsp_stall = (n != 0);
			repeat (n) @(negedge clk);
			rsp_stall = 1'b0;
			repeat (($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 6)) @(negedge clk);
		end
	end

	task automatic push(input nfrc_pkg::req_t item);
		repeat (idle_cycles()) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_bus = item;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic send_load(input logic first, input logic [15:0] lft, input logic [15:0] rgt);
		nfrc_pkg::req_t item;
		item.req_type = nfrc_pkg::REQ_LOAD;
		item.first_of_block = first;
		item.src_left = lft;
		item.src_right = rgt;
		item.dst_frame_total = 16'($urandom);
		push(item);
	endtask

	task automatic send_emit(input logic [15:0] total);
		nfrc_pkg::req_t item;
		item.req_type = nfrc_pkg::REQ_EMIT;
		item.first_of_block = 1'($urandom);
		item.src_left = 16'($urandom);
		item.src_right = 16'($urandom);
		item.dst_frame_total = total;
		push(item);
	endtask

	task automatic set_reg(input logic idx, input logic [2:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_mode(input logic [2:0] fmt, input logic stereo);
		set_reg(nfrc_pkg::REG_DST_FORMAT, fmt);
		set_reg(nfrc_pkg::REG_SRC_IS_STEREO, {2'($urandom), stereo});
	endtask

	initial begin
		nfrc_pkg::req_t item;
		int             n;
		int             t;
		int             m;
		int             sent;
		bit             held;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_bus = '0;
		cfg_valid = 1'b0;
		cfg_index = nfrc_pkg::REG_DST_FORMAT;
		cfg_data = nfrc_pkg::FMT_I16;
		quiet = 1'b0;
		hold_now = 1'b0;
		held = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_mode(nfrc_pkg::FMT_I16, 1'b0);

		// empty store, then tiny blocks, index past the block end, zero total
		send_emit(16'd1);
		send_emit(16'd0);
		send_emit(16'hffff);
		send_load(1'b1, 16'h7fff, 16'h8000);
		send_emit(16'd1);
		send_emit(16'd2);
		send_load(1'b0, 16'h8000, 16'h7fff);
		send_load(1'b0, 16'h0000, 16'h0000);
		send_load(1'b0, 16'hffff, 16'h0001);
		send_load(1'b0, 16'h0001, 16'hffff);
		repeat (3) send_emit(16'd8);
		send_emit(16'd2);
		send_emit(16'd0);
		repeat (4) send_emit(16'd3);
		send_load(1'b1, 16'h4000, 16'hc000);
		send_emit(16'hffff);
		send_emit(16'd1);
		drain();

		// fill the store past its depth; the extra loads are dropped
		quiet = 1'b1;
		set_mode(nfrc_pkg::FMT_FLOAT, 1'b1);
		send_load(1'b1, rnd_sample(), rnd_sample());
		repeat (nfrc_pkg::MAX_SRC_FRAMES_DEF + 2) send_load(1'b0, rnd_sample(), rnd_sample());
		repeat (4) send_emit(16'hffff);
		send_emit(16'(nfrc_pkg::MAX_SRC_FRAMES_DEF));
		send_emit(16'd3);
		repeat (6) send_emit(rnd_total());
		send_load(1'b1, rnd_sample(), rnd_sample());
		repeat (2) send_emit(16'd2);
		quiet = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_mode(fmt_plan[p], 1'(p));
			quiet = (p == 6);
			sent = 0;
			while (sent < PHASE_LEN) begin
				if ($urandom_range(0, 9) < 8) begin
					case ($urandom_range(0, 9))
						0: n = 0;
						1, 2, 3: n = $urandom_range(9, 40);
						default: n = $urandom_range(1, 8);
					endcase
					for (int i = 0; i < n; i++) begin
						send_load(i == 0 || $urandom_range(0, 19) == 0,
							rnd_sample(), rnd_sample());
					end
					case ($urandom_range(0, 9))
						7, 8: t = $urandom_range(25, 200);
						9: t = rnd_total();
						default: t = $urandom_range(1, 24);
					endcase
					m = (t >= 1 && t <= 48) ? t : $urandom_range(1, 48);
					if ($urandom_range(0, 3) == 0) begin
						m += $urandom_range(1, 5);
					end else if ($urandom_range(0, 6) == 0) begin
						m = $urandom_range(1, m);
					end
					if (p == 2 && !held) begin
						hold_now = 1'b1;
						held = 1'b1;
					end
					repeat (m) send_emit(16'(t));
					sent += n + m;
				end else begin
					item.req_type = 1'($urandom);
					item.first_of_block = 1'($urandom);
					item.src_left = rnd_sample();
					item.src_right = rnd_sample();
					item.dst_frame_total = rnd_total();
					push(item);
					sent++;
				end
			end
		end

		req_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (64) @(negedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/nfrc_pkg.sv
rtl/core/nearest_frame_resample_format_convert_unit.sv
test/nfrc_checker.sv
test/tb_nearest_frame_resample_format_convert_unit.sv
